// ----- rtl/accel_pedometer_step_tracker_defines.svh -----
// assertion macros used by rtl/accel_pedometer_step_tracker.sv
`ifndef ACCEL_PEDOMETER_STEP_TRACKER_DEFINES_SVH
`define ACCEL_PEDOMETER_STEP_TRACKER_DEFINES_SVH

// condition implies consequence on the next edge
`define APST_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");

// condition implies consequence on the same edge
`define APST_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");

`endif

// ----- rtl/apst_pkg.sv -----
`default_nettype none
package apst_pkg;
  localparam int STEP_HISTORY = 6;
  localparam int RING_AW = $clog2(STEP_HISTORY);

  localparam logic [2:0] CFG_WAKE = 3'd0;
  localparam logic [2:0] CFG_PEAK = 3'd1;
  localparam logic [2:0] CFG_REARM = 3'd2;
  localparam logic [2:0] CFG_REFR = 3'd3;
  localparam logic [2:0] CFG_STRIDE = 3'd4;
  localparam logic [2:0] CFG_SPEED = 3'd5;
  localparam logic [2:0] CFG_GAP = 3'd6;
  localparam logic [2:0] CFG_WINDOW = 3'd7;

  localparam logic [1:0] CLR_NONE = 2'd0;
  localparam logic [1:0] CLR_STEPS = 2'd1;
  localparam logic [1:0] CLR_ALL = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQ, ST_SQRT, ST_BASE, ST_UPD, ST_SPD_LD, ST_SPD_DIV,
    ST_AVG_LD, ST_AVG_DIV, ST_OUT
  } state_t;

  // iterative divider command and status
  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [39:0] den;
  } div_cmd_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quo;
  } div_sts_t;
endpackage
`default_nettype wire

// ----- rtl/apst_if.sv -----
`default_nettype none
interface apst_in_if;
  logic               valid;
  logic               ready;
  logic signed [12:0] accel_x;
  logic signed [12:0] accel_y;
  logic signed [12:0] accel_z;
  logic [31:0]        time_ms;
  logic [1:0]         clear_mode;
  logic               take_motion;
  modport source (output valid, accel_x, accel_y, accel_z, time_ms, clear_mode,
    take_motion, input ready);
  modport sink (input valid, accel_x, accel_y, accel_z, time_ms, clear_mode,
    take_motion, output ready);
endinterface

interface apst_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] step_count;
  logic        step_seen;
  logic [31:0] distance_mm;
  logic [15:0] max_speed_mm_s;
  logic [15:0] avg_speed_mm_s;
  logic        motion_flag;
  modport source (output valid, step_count, step_seen, distance_mm, max_speed_mm_s,
    avg_speed_mm_s, motion_flag, input ready);
  modport sink (input valid, step_count, step_seen, distance_mm, max_speed_mm_s,
    avg_speed_mm_s, motion_flag, output ready);
endinterface
`default_nettype wire

// ----- rtl/apst_isqrt.sv -----
`default_nettype none
module apst_isqrt
  import apst_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [25:0] n,
  output logic             done,
  output logic [12:0]      root
);
  // one result bit per cycle, two radicand bits shifted in per cycle
  logic [25:0] n_r, n_nxt;
  logic [14:0] rem_r, rem_nxt;
  logic [12:0] q_r, q_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [14:0] trial;
  logic [14:0] cand;

  always_comb begin
    cand = {rem_r[12:0], n_r[25:24]};
    trial = {q_r, 2'b01};
    n_nxt = n_r;
    rem_nxt = rem_r;
    q_nxt = q_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      n_nxt = n;
      rem_nxt = '0;
      q_nxt = '0;
      cnt_nxt = 4'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      n_nxt = {n_r[23:0], 2'b00};
      if (cand >= trial) begin
        rem_nxt = cand - trial;
        q_nxt = {q_r[11:0], 1'b1};
      end else begin
        rem_nxt = cand;
        q_nxt = {q_r[11:0], 1'b0};
      end
      cnt_nxt = cnt_r + 4'd1;
      if (cnt_r == 4'd12) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    n_r <= n_nxt;
    rem_r <= rem_nxt;
    q_r <= q_nxt;
  end

  assign done = busy_r && (cnt_r == 4'd12);
  assign root = {q_r[11:0], (cand >= trial)};
endmodule
`default_nettype wire

// ----- rtl/apst_div.sv -----
`default_nettype none
module apst_div
  import apst_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  div_cmd_t  cmd,
  output div_sts_t  sts
);
  // restoring divider, one quotient bit per cycle
  logic [63:0] q_r, q_nxt;
  logic [40:0] rem_r, rem_nxt;
  logic [39:0] den_r, den_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [40:0] sh;

  always_comb begin
    sh = {rem_r[39:0], q_r[63]};
    q_nxt = q_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (cmd.start) begin
      q_nxt = cmd.num;
      rem_nxt = '0;
      den_nxt = cmd.den;
      cnt_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (sh >= {1'b0, den_r}) begin
        rem_nxt = sh - {1'b0, den_r};
        q_nxt = {q_r[62:0], 1'b1};
      end else begin
        rem_nxt = sh;
        q_nxt = {q_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign sts.done = done_r;
  assign sts.quo = q_r;
endmodule
`default_nettype wire

// ----- rtl/accel_pedometer_step_tracker.sv -----
// Pedometer: one accelerometer sample item in, one statistics item out.
// The magnitude comes from a bit-serial square root, the baseline
// product from a 32 by 12 bit multiplier, and the step speed and average speed
// from one shared restoring divider, one quotient bit per cycle. The average
// speed is divided only when the moving time is above 1000 ms, and the step
// speed only for a counted step with enough history.
// in_ready is high only between items; the result sits in an output register
// until taken, and a new sample is taken once that register is free.
// Configuration writes are taken at any time but are meant for idle periods.
`default_nettype none
`include "accel_pedometer_step_tracker_defines.svh"
module accel_pedometer_step_tracker
  import apst_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  apst_in_if.sink          in_ch,
  apst_out_if.source       out_ch,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);
  // configuration registers
  logic [12:0] wake_r, peak_r, rearm_r;
  logic [15:0] refr_r, spdlim_r, gap_r, window_r;
  logic [11:0] stride_r;

  // tracker state
  state_t st_r, st_nxt;
  logic signed [30:0] base_r;
  logic               armed_r, motion_r;
  logic [31:0]        last_step_r, last_samp_r, steps_r, dist_r;
  logic [15:0]        best_r;
  logic [39:0]        mov_r;
  logic [31:0]        ring_r [STEP_HISTORY];
  logic [RING_AW-1:0] head_r;
  logic [RING_AW:0]   fill_r;

  // sample holding
  logic signed [12:0] ax_r, ay_r, az_r;
  logic [31:0]        now_r;
  logic               take_r, seen_r;
  logic [25:0]        sumsq_r;
  logic [1:0]         sq_idx_r;
  logic [12:0]        mag_r;
  logic signed [31:0] ac_r;
  logic [31:0]        span_r;
  logic [15:0]        avg_r;

  // output register
  logic        ov_r;
  logic [31:0] o_steps_r, o_dist_r;
  logic        o_seen_r, o_motion_r;
  logic [15:0] o_best_r, o_avg_r;

  logic in_fire, out_fire;
  assign in_ch.ready = (st_r == ST_IDLE) && !ov_r;
  assign in_fire = in_ch.valid && in_ch.ready;
  assign out_fire = ov_r && out_ch.ready;

  // one squaring per cycle over three axes
  logic signed [12:0] sq_in;
  logic [25:0]        sq_val;
  logic [25:0]        sumsq_all;
  always_comb begin
    case (sq_idx_r)
      2'd0: sq_in = ax_r;
      2'd1: sq_in = ay_r;
      default: sq_in = az_r;
    endcase
    sq_val = 26'($signed(sq_in) * $signed(sq_in));
    // full sum of squares once the last axis is added
    sumsq_all = sumsq_r + sq_val;
  end

  // square root unit
  logic        sq_start, sq_done;
  logic [12:0] sq_root;
  apst_isqrt u_isqrt (.clk(clk), .rst_n(rst_n), .start(sq_start), .n(sumsq_all),
    .done(sq_done), .root(sq_root));

  // shared divider
  div_cmd_t dcmd;
  div_sts_t dsts;
  apst_div u_div (.clk(clk), .rst_n(rst_n), .cmd(dcmd), .sts(dsts));

  // baseline update and motion component
  logic signed [31:0] d_q;
  logic signed [47:0] prod;
  logic signed [31:0] stepv, base_new, ac_new;
  always_comb begin
    d_q = $signed({3'b000, mag_r, 16'h0}) - 32'(base_r);
    prod = 48'(d_q) * 48'sd3277;
    stepv = 32'(prod >>> 16); // floor for both signs
    base_new = 32'(base_r) + stepv;
    ac_new = $signed({3'b000, mag_r, 16'h0}) - base_new;
  end

  // step decision
  logic [31:0] since_step, dt;
  logic        step_hit, mov_add;
  logic [40:0] mov_sum;
  logic [RING_AW-1:0] head_inc, oldest;
  logic [RING_AW:0]   fill_new;
  logic [RING_AW+1:0] old_tmp;
  always_comb begin
    since_step = now_r - last_step_r;
    dt = now_r - last_samp_r;
    step_hit = (ac_r > $signed({3'b000, peak_r, 16'h0})) && armed_r &&
               (since_step > {16'h0, refr_r});
    mov_add = (last_samp_r != 32'd0) && (dt < {16'h0, gap_r}) &&
              (since_step < {16'h0, window_r});
    mov_sum = {1'b0, mov_r} + {9'h0, dt};
    head_inc = (head_r == RING_AW'(STEP_HISTORY - 1)) ? '0 : head_r + 1'b1;
    fill_new = (fill_r < (RING_AW+1)'(STEP_HISTORY)) ? fill_r + 1'b1 : fill_r;
    old_tmp = (RING_AW+2)'(head_inc) + (RING_AW+2)'(STEP_HISTORY) -
              (RING_AW+2)'(fill_new);
    oldest = (old_tmp >= (RING_AW+2)'(STEP_HISTORY)) ?
             RING_AW'(old_tmp - (RING_AW+2)'(STEP_HISTORY)) : RING_AW'(old_tmp);
  end

  // small products for divider operands
  logic [25:0] spd_num;
  logic [41:0] avg_num;
  always_comb begin
    spd_num = 26'(({22'h0, fill_r} - 26'd1) * 26'(stride_r) * 26'd1000);
    avg_num = 42'(dist_r) * 42'd1000;
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (in_fire) st_nxt = ST_SQ;
      ST_SQ: if (sq_idx_r == 2'd2) st_nxt = ST_SQRT;
      ST_SQRT: if (sq_done) st_nxt = ST_BASE;
      ST_BASE: st_nxt = ST_UPD;
      ST_UPD: begin
        if (step_hit && fill_new >= (RING_AW+1)'(2)) st_nxt = ST_SPD_LD;
        else st_nxt = ST_AVG_LD;
      end
      ST_SPD_LD: st_nxt = (span_r != 32'd0) ? ST_SPD_DIV : ST_AVG_LD;
      ST_SPD_DIV: if (dsts.done) st_nxt = ST_AVG_LD;
      ST_AVG_LD: st_nxt = (mov_r > 40'd1000) ? ST_AVG_DIV : ST_OUT;
      ST_AVG_DIV: if (dsts.done) st_nxt = ST_OUT;
      ST_OUT: st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // unit controls
  always_comb begin
    sq_start = (st_r == ST_SQ) && (sq_idx_r == 2'd2);
    dcmd.start = 1'b0;
    dcmd.num = '0;
    dcmd.den = '0;
    if (st_r == ST_SPD_LD && span_r != 32'd0) begin
      dcmd.start = 1'b1;
      dcmd.num = 64'(spd_num);
      dcmd.den = 40'(span_r);
    end else if (st_r == ST_AVG_LD && mov_r > 40'd1000) begin
      dcmd.start = 1'b1;
      dcmd.num = 64'(avg_num);
      dcmd.den = mov_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      wake_r <= 13'd250; peak_r <= 13'd180; rearm_r <= 13'd80;
      refr_r <= 16'd300; stride_r <= 12'd720; spdlim_r <= 16'd6000;
      gap_r <= 16'd500; window_r <= 16'd2500;
      base_r <= 31'sd65536000;
      armed_r <= 1'b1; motion_r <= 1'b0;
      last_step_r <= '0; last_samp_r <= '0; steps_r <= '0; dist_r <= '0;
      best_r <= '0; mov_r <= '0; head_r <= '0; fill_r <= '0;
      ov_r <= 1'b0; sq_idx_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_WAKE: wake_r <= cfg_wdata[12:0];
          CFG_PEAK: peak_r <= cfg_wdata[12:0];
          CFG_REARM: rearm_r <= cfg_wdata[12:0];
          CFG_REFR: refr_r <= cfg_wdata;
          CFG_STRIDE: stride_r <= cfg_wdata[11:0];
          CFG_SPEED: spdlim_r <= cfg_wdata;
          CFG_GAP: gap_r <= cfg_wdata;
          CFG_WINDOW: window_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (out_fire) ov_r <= 1'b0;
      case (st_r)
        ST_IDLE: if (in_fire) begin
          sq_idx_r <= '0;
          case (in_ch.clear_mode)
            CLR_STEPS: steps_r <= '0;
            CLR_ALL: begin
              steps_r <= '0; dist_r <= '0; best_r <= '0; mov_r <= '0;
              head_r <= '0; fill_r <= '0; last_step_r <= '0;
            end
            default: ;
          endcase
        end
        ST_SQ: sq_idx_r <= sq_idx_r + 2'd1;
        ST_BASE: begin
          base_r <= 31'(base_new);
          ac_r <= ac_new;
          if ((ac_new > $signed({3'b000, wake_r, 16'h0})) ||
              (ac_new < -$signed({3'b000, wake_r, 16'h0}))) motion_r <= 1'b1;
        end
        ST_UPD: begin
          if (mov_add) mov_r <= mov_sum[40] ? 40'hFF_FFFF_FFFF : mov_sum[39:0];
          last_samp_r <= now_r;
          if (step_hit) begin
            steps_r <= steps_r + 32'd1;
            last_step_r <= now_r;
            armed_r <= 1'b0;
            dist_r <= dist_r + 32'(stride_r);
            head_r <= head_inc;
            fill_r <= fill_new;
            span_r <= now_r - ((oldest == head_r) ? now_r : ring_r[oldest]);
          end else if (ac_r < $signed({3'b000, rearm_r, 16'h0})) begin
            armed_r <= 1'b1;
          end
        end
        ST_SPD_DIV: if (dsts.done) begin
          if (dsts.quo < 64'(spdlim_r) && dsts.quo > 64'(best_r))
            best_r <= dsts.quo[15:0];
        end
        ST_OUT: begin
          ov_r <= 1'b1;
          if (take_r) motion_r <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      ax_r <= in_ch.accel_x; ay_r <= in_ch.accel_y; az_r <= in_ch.accel_z;
      now_r <= in_ch.time_ms; take_r <= in_ch.take_motion;
      sumsq_r <= '0; seen_r <= 1'b0; avg_r <= '0;
    end
    if (st_r == ST_SQ) sumsq_r <= sumsq_all;
    if (sq_done) mag_r <= sq_root;
    if (st_r == ST_UPD) begin
      seen_r <= step_hit;
      if (step_hit) ring_r[head_r] <= now_r;
    end
    if (st_r == ST_AVG_DIV && dsts.done)
      avg_r <= (dsts.quo > 64'd65535) ? 16'hFFFF : dsts.quo[15:0];
    if (st_r == ST_OUT) begin
      o_steps_r <= steps_r; o_seen_r <= seen_r; o_dist_r <= dist_r;
      o_best_r <= best_r; o_avg_r <= avg_r; o_motion_r <= motion_r;
    end
  end

  assign out_ch.valid = ov_r;
  assign out_ch.step_count = o_steps_r;
  assign out_ch.step_seen = o_seen_r;
  assign out_ch.distance_mm = o_dist_r;
  assign out_ch.max_speed_mm_s = o_best_r;
  assign out_ch.avg_speed_mm_s = o_avg_r;
  assign out_ch.motion_flag = o_motion_r;

  `APST_ASSERT_NEXT(a_one_item, in_fire, !in_ch.ready)
  `APST_ASSERT_NOW(a_no_accept_full, ov_r, !in_ch.ready)
  `APST_ASSERT_NEXT(a_out_set, st_r == ST_OUT, ov_r)
  `APST_ASSERT_NOW(a_fill_bound, 1'b1, fill_r <= (RING_AW+1)'(STEP_HISTORY))
endmodule
`default_nettype wire
